// ----- src/osut_pkg.sv -----
// Shared constants and types for the oversampled UART transceiver.
// No dependencies; the top level refers to it by scoped names.
package osut_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SEND = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAUD_DIVISOR = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RX_ENABLE    = 1'd1;

    // Reset values and fixed widths
    localparam int          DEFAULT_RX_FIFO_DEPTH = 16;
    localparam logic [7:0]  BAUD_DIVISOR_RESET    = 8'd3;
    localparam logic        RX_ENABLE_RESET       = 1'b1;
    localparam int          CNT_W                 = 4;
    localparam logic [3:0]  RX_FRAME_BITS         = 4'd10;
    localparam logic [7:0]  TX_MASK_FIRST         = 8'h01;
    localparam logic [7:0]  TX_MASK_LAST          = 8'h80;

endpackage

// ----- src/osut_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osut_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/oversampled_uart_transceiver.sv -----
// Oversampled UART transceiver, one 8N1 channel, one item per command.
// An item is captured in the input register, then its result in the result
// register. Throughput: one item per cycle unless a held result stalls it;
// the state update and result sit in one logic pass between the two registers.
// Reset: control state, config registers and the ring valid bits clear at
// once (entries never written read as zero); no clearing pass is needed.
module oversampled_uart_transceiver #(
    parameter int RX_FIFO_DEPTH = osut_pkg::DEFAULT_RX_FIFO_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [osut_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    // input items
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic                           rx_line,
    input  logic [7:0]                     tx_data,
    // result items
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           tx_line,
    output logic                           tx_busy,
    output logic                           send_accepted,
    output logic [osut_pkg::CNT_W-1:0]     rx_count,
    output logic [7:0]                     read_data,
    output logic                           rx_byte_done
);

    localparam int PTR_W = $clog2(RX_FIFO_DEPTH);

    typedef enum logic [1:0] {
        TX_IDLE  = 2'd0,
        TX_START = 2'd1,
        TX_DATA  = 2'd2,
        TX_STOP  = 2'd3
    } tx_state_t;

    // ---------------- registers ----------------
    // config
    logic [7:0]         div_reg;
    logic               rx_en_reg;
    // input stage
    logic               s1_valid_reg;
    osut_pkg::cmd_t     s1_cmd_reg;
    logic               s1_line_reg;
    logic [7:0]         s1_data_reg;
    // read-side bookkeeping captured with the RAM read
    logic               rd_valid_reg;
    logic               rd_hit_reg;
    logic [7:0]         rd_byp_reg;
    // block state
    logic [7:0]         phase_reg,  phase_next;
    logic [3:0]         rx_cnt_reg, rx_cnt_next;
    logic [7:0]         rx_sph_reg, rx_sph_next;
    logic [7:0]         rx_shift_reg, rx_shift_next;
    logic [PTR_W-1:0]   head_reg,   head_next;
    logic [PTR_W-1:0]   tail_reg,   tail_next;
    tx_state_t          tx_state_reg, tx_state_next;
    logic [7:0]         tx_mask_reg, tx_mask_next;
    logic [7:0]         tx_byte_reg, tx_byte_next;
    logic               tx_level_reg, tx_level_next;
    logic [RX_FIFO_DEPTH-1:0] vbits_reg;
    // result register
    logic               out_valid_reg;
    logic               tx_line_reg;
    logic               tx_busy_reg;
    logic               send_acc_reg, send_acc_next;
    logic [osut_pkg::CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [7:0]         read_data_reg, read_data_next;
    logic               done_reg, done_next;

    // ---------------- handshake ----------------
    logic               s1_go;
    logic               in_acc;
    logic               ring_we;
    logic [7:0]         ram_q;
    logic               rd_hit;

    assign s1_go     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_go;
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // ---------------- single-pass item logic ----------------
    logic [7:0]         pc_inc;
    logic [7:0]         pc_new;
    logic [8:0]         sp_sum;
    logic [8:0]         sp_red;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   tail_inc;
    logic [PTR_W:0]     diff;

    always_comb
    begin
        phase_next    = phase_reg;
        rx_cnt_next   = rx_cnt_reg;
        rx_sph_next   = rx_sph_reg;
        rx_shift_next = rx_shift_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        tx_state_next = tx_state_reg;
        tx_mask_next  = tx_mask_reg;
        tx_byte_next  = tx_byte_reg;
        tx_level_next = tx_level_reg;
        send_acc_next = 1'b0;
        read_data_next = 8'd0;
        done_next     = 1'b0;
        ring_we       = 1'b0;

        head_inc = (head_reg == PTR_W'(RX_FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_inc = (tail_reg == PTR_W'(RX_FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;

        // phase counter wraps at the divisor; divisor zero pins it at 0
        pc_inc = phase_reg + 8'd1;
        pc_new = (pc_inc >= div_reg) ? 8'd0 : pc_inc;

        // mid-bit sample phase, half a bit after the start edge
        sp_sum = {1'b0, pc_new} + {2'b00, div_reg[7:1]};
        if (div_reg == 8'd0)
        begin
            sp_red = 9'd0;
        end
        else if (sp_sum >= {1'b0, div_reg})
        begin
            sp_red = sp_sum - {1'b0, div_reg};
        end
        else
        begin
            sp_red = sp_sum;
        end

        if (s1_go)
        begin
            case (s1_cmd_reg)
                osut_pkg::CMD_TICK:
                begin
                    phase_next = pc_new;
                    // receiver
                    if (rx_en_reg)
                    begin
                        if (rx_cnt_reg != 4'd0)
                        begin
                            if (pc_new == rx_sph_reg)
                            begin
                                rx_shift_next = {s1_line_reg, rx_shift_reg[7:1]};
                                rx_cnt_next   = rx_cnt_reg + 4'd1;
                                if (rx_cnt_next >= osut_pkg::RX_FRAME_BITS)
                                begin
                                    rx_cnt_next = 4'd0;
                                    ring_we     = 1'b1;
                                    head_next   = head_inc;
                                    done_next   = 1'b1;
                                end
                            end
                        end
                        else if (!s1_line_reg)
                        begin
                            rx_sph_next   = sp_red[7:0];
                            rx_cnt_next   = 4'd1;
                            rx_shift_next = 8'd0;
                        end
                    end
                    else
                    begin
                        rx_cnt_next = 4'd0;
                    end
                    // transmitter steps one bit at phase zero
                    if (pc_new == 8'd0)
                    begin
                        case (tx_state_reg)
                            TX_START:
                            begin
                                tx_level_next = 1'b0;
                                tx_state_next = TX_DATA;
                                tx_mask_next  = osut_pkg::TX_MASK_FIRST;
                            end
                            TX_DATA:
                            begin
                                tx_level_next = |(tx_byte_reg & tx_mask_reg);
                                if (|(tx_mask_reg & osut_pkg::TX_MASK_LAST))
                                begin
                                    tx_state_next = TX_STOP;
                                end
                                else
                                begin
                                    tx_mask_next = {tx_mask_reg[6:0], 1'b0};
                                end
                            end
                            TX_STOP:
                            begin
                                tx_level_next = 1'b1;
                                tx_mask_next  = osut_pkg::TX_MASK_FIRST;
                                tx_state_next = TX_IDLE;
                            end
                            default:
                            begin
                                tx_state_next = tx_state_reg;
                            end
                        endcase
                    end
                end
                osut_pkg::CMD_SEND:
                begin
                    if (tx_state_reg == TX_IDLE)
                    begin
                        tx_byte_next  = s1_data_reg;
                        tx_state_next = TX_START;
                        send_acc_next = 1'b1;
                    end
                end
                osut_pkg::CMD_READ:
                begin
                    // stale entry on empty read (zero if the slot was never written); tail moves regardless
                    if (rd_hit_reg)
                    begin
                        read_data_next = rd_byp_reg;
                    end
                    else if (rd_valid_reg)
                    begin
                        read_data_next = ram_q;
                    end
                    tail_next = tail_inc;
                end
                default:
                begin
                    tail_next = tail_reg;
                end
            endcase
        end

        // ring occupancy, head minus tail modulo depth
        if (head_next >= tail_next)
        begin
            diff = {1'b0, head_next} - {1'b0, tail_next};
        end
        else
        begin
            diff = {1'b0, head_next} + (PTR_W + 1)'(RX_FIFO_DEPTH) - {1'b0, tail_next};
        end
        rx_count_next = osut_pkg::CNT_W'(diff);
    end

    // The next item's ring read goes out as it is accepted, at the tail left
    // by the item now finishing; a same-cycle store at that slot is bypassed.
    assign rd_hit = ring_we && (head_reg == tail_next);

    osut_ram #(
        .WIDTH  (8),
        .DEPTH  (RX_FIFO_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_we),
        .wr_addr (head_reg),
        .wr_data (rx_shift_next),
        .rd_en   (in_acc),
        .rd_addr (tail_next),
        .rd_data (ram_q)
    );

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg       <= osut_pkg::BAUD_DIVISOR_RESET;
            rx_en_reg     <= osut_pkg::RX_ENABLE_RESET;
            s1_valid_reg  <= 1'b0;
            s1_cmd_reg    <= osut_pkg::CMD_NOP;
            s1_line_reg   <= 1'b1;
            s1_data_reg   <= 8'd0;
            rd_valid_reg  <= 1'b0;
            rd_hit_reg    <= 1'b0;
            rd_byp_reg    <= 8'd0;
            phase_reg     <= 8'd0;
            rx_cnt_reg    <= 4'd0;
            rx_sph_reg    <= 8'd0;
            rx_shift_reg  <= 8'd0;
            head_reg      <= '0;
            tail_reg      <= '0;
            tx_state_reg  <= TX_IDLE;
            tx_mask_reg   <= osut_pkg::TX_MASK_FIRST;
            tx_byte_reg   <= 8'd0;
            tx_level_reg  <= 1'b1;
            vbits_reg     <= '0;
            out_valid_reg <= 1'b0;
            tx_line_reg   <= 1'b1;
            tx_busy_reg   <= 1'b0;
            send_acc_reg  <= 1'b0;
            rx_count_reg  <= '0;
            read_data_reg <= 8'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            // the user must send config writes only while the block is idle; the block does not enforce it
            if (cfg_valid)
            begin
                case (cfg_index)
                    osut_pkg::CFG_BAUD_DIVISOR: div_reg   <= cfg_data;
                    osut_pkg::CFG_RX_ENABLE:    rx_en_reg <= cfg_data[0];
                    default:                    div_reg   <= div_reg;
                endcase
            end

            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
                s1_cmd_reg   <= osut_pkg::cmd_t'(command);
                s1_line_reg  <= rx_line;
                s1_data_reg  <= tx_data;
                rd_valid_reg <= vbits_reg[tail_next] || rd_hit;
                rd_hit_reg   <= rd_hit;
                rd_byp_reg   <= rx_shift_next;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            phase_reg    <= phase_next;
            rx_cnt_reg   <= rx_cnt_next;
            rx_sph_reg   <= rx_sph_next;
            rx_shift_reg <= rx_shift_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            tx_state_reg <= tx_state_next;
            tx_mask_reg  <= tx_mask_next;
            tx_byte_reg  <= tx_byte_next;
            tx_level_reg <= tx_level_next;
            if (ring_we)
            begin
                vbits_reg[head_reg] <= 1'b1;
            end

            if (s1_go)
            begin
                out_valid_reg <= 1'b1;
                tx_line_reg   <= tx_level_next;
                tx_busy_reg   <= (tx_state_next != TX_IDLE);
                send_acc_reg  <= send_acc_next;
                rx_count_reg  <= rx_count_next;
                read_data_reg <= read_data_next;
                done_reg      <= done_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign tx_line       = tx_line_reg;
    assign tx_busy       = tx_busy_reg;
    assign send_accepted = send_acc_reg;
    assign rx_count      = rx_count_reg;
    assign read_data     = read_data_reg;
    assign rx_byte_done  = done_reg;

endmodule
